// ----- rtl/rvig_pkg.sv -----
// shared types and constants for the radial vignette pixel block
package rvig_pkg;

    localparam int RVIG_MAX_DIM = 4096;

    // field widths
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int CH_W    = 8;
    localparam int STR_W   = 8;

    // apb port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_STRENGTH     = 2'd2
    } t_reg_idx;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd1080;
    localparam logic [STR_W-1:0] STRENGTH_RST     = 8'd0;

    // distance and ratio datapath
    localparam int SQ_W       = 2 * DIM_W;
    localparam int D2_W       = SQ_W + 1;
    localparam int Q_W        = 32;
    localparam int ROOT_W     = 16;
    localparam int SREM_W     = ROOT_W + 1;
    localparam int RATIO_W    = ROOT_W + 1;
    localparam int DIV_STEPS  = Q_W;
    localparam int SQRT_STEPS = Q_W / 2;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

    // drop = floor(ratio * strength / 100) via reciprocal, exact for prod < 2^24
    localparam int PROD_W      = 24;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 31;
    localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;
    localparam int DROP_W      = 18;
    localparam int MASK_W      = RATIO_W;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_pix;

    typedef struct packed {
        logic zero;
        logic one;
        t_pix pix;
    } t_tag;

endpackage

// ----- rtl/rvig_in_if.sv -----
// pixel input channel: position and channel bytes with valid/ready
interface rvig_in_if;
    logic                         valid;
    logic                         ready;
    logic [rvig_pkg::COORD_W-1:0] col;
    logic [rvig_pkg::COORD_W-1:0] row;
    logic [rvig_pkg::CH_W-1:0]    blue_in;
    logic [rvig_pkg::CH_W-1:0]    green_in;
    logic [rvig_pkg::CH_W-1:0]    red_in;

    modport source (output valid, col, row, blue_in, green_in, red_in, input ready);
    modport sink (input valid, col, row, blue_in, green_in, red_in, output ready);
endinterface

// ----- rtl/rvig_out_if.sv -----
// pixel output channel: scaled channel bytes with valid/ready
interface rvig_out_if;
    logic                      valid;
    logic                      ready;
    logic [rvig_pkg::CH_W-1:0] blue_out;
    logic [rvig_pkg::CH_W-1:0] green_out;
    logic [rvig_pkg::CH_W-1:0] red_out;

    modport source (output valid, blue_out, green_out, red_out, input ready);
    modport sink (input valid, blue_out, green_out, red_out, output ready);
endinterface

// ----- rtl/rvig_ratio.sv -----
// pipelined floor(sqrt(d2/m2) * 2^16): restoring divide then digit-by-digit square root
module rvig_ratio (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [rvig_pkg::D2_W-1:0]     i_d2,
    input  logic [rvig_pkg::D2_W-1:0]     i_m2,
    input  rvig_pkg::t_pix                i_pix,
    output logic                          o_vld,
    output logic [rvig_pkg::RATIO_W-1:0]  o_ratio,
    output rvig_pkg::t_pix                o_pix
);

    localparam int D2_W   = rvig_pkg::D2_W;
    localparam int Q_W    = rvig_pkg::Q_W;
    localparam int ROOT_W = rvig_pkg::ROOT_W;
    localparam int SREM_W = rvig_pkg::SREM_W;
    localparam int NDIV   = rvig_pkg::DIV_STEPS;
    localparam int NSQRT  = rvig_pkg::SQRT_STEPS;
    localparam int LAST   = NDIV + NSQRT;

    logic                r_vld  [0:LAST];
    rvig_pkg::t_tag      r_tag  [0:LAST];
    logic [D2_W-1:0]     r_drem [0:NDIV];
    logic [Q_W-1:0]      r_quo  [0:NDIV];
    logic [SREM_W-1:0]   r_srem [1:NSQRT];
    logic [ROOT_W-1:0]   r_root [1:NSQRT];
    logic [Q_W-1:0]      r_sq   [1:NSQRT];

    logic                          r_out_vld;
    logic [rvig_pkg::RATIO_W-1:0]  r_ratio;
    rvig_pkg::t_pix                r_out_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= LAST; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s <= LAST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_out_vld <= r_vld[LAST];
        end
    end

    // the user must keep m2 fixed while items are in flight (not enforced here), so every stage reads it directly
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0].zero <= (i_m2 == '0);
            r_tag[0].one  <= (i_d2 >= i_m2);
            r_tag[0].pix  <= i_pix;
            for (int s = 1; s <= LAST; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
            r_drem[0] <= i_d2;
            r_quo[0]  <= '0;
        end
    end

    // one quotient bit per stage; remainder stays below m2 when d2 < m2
    for (genvar k = 1; k <= NDIV; k++) begin : g_div
        logic [D2_W:0] sh;
        logic          ge;

        assign sh = {r_drem[k-1], 1'b0};
        assign ge = (sh >= {1'b0, i_m2});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[k] <= ge ? D2_W'(sh - {1'b0, i_m2}) : sh[D2_W-1:0];
                r_quo[k]  <= {r_quo[k-1][Q_W-2:0], ge};
            end
        end
    end

    // one root bit per stage, two radicand bits consumed each time
    for (genvar k = 1; k <= NSQRT; k++) begin : g_sqrt
        logic [SREM_W-1:0] rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [Q_W-1:0]    sq_prev;
        logic [SREM_W+1:0] cur;
        logic [SREM_W:0]   trial;
        logic              ge;

        if (k == 1) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign sq_prev   = r_quo[NDIV];
        end else begin : g_next
            assign rem_prev  = r_srem[k-1];
            assign root_prev = r_root[k-1];
            assign sq_prev   = r_sq[k-1];
        end

        assign cur   = {rem_prev, sq_prev[Q_W-1 -: 2]};
        assign trial = {root_prev, 2'b01};
        assign ge    = (cur >= {1'b0, trial});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_srem[k] <= ge ? SREM_W'(cur - {1'b0, trial}) : cur[SREM_W-1:0];
                r_root[k] <= {root_prev[ROOT_W-2:0], ge};
                r_sq[k]   <= {sq_prev[Q_W-3:0], 2'b00};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_tag[LAST].zero) begin
                r_ratio <= '0;
            end else if (r_tag[LAST].one) begin
                r_ratio <= rvig_pkg::RATIO_ONE;
            end else begin
                r_ratio <= {1'b0, r_root[NSQRT]};
            end
            r_out_pix <= r_tag[LAST].pix;
        end
    end

    assign o_vld   = r_out_vld;
    assign o_ratio = r_ratio;
    assign o_pix   = r_out_pix;

endmodule

// ----- rtl/radial_vignette_pixel_top.sv -----
// radial vignette pixel block: apb registers, distance stages, ratio unit, mask and scaling
// throughput: one pixel per cycle; the whole 58-stage pipeline advances together, and it holds
// only while its last stage has a result that is not taken
// reset (i_rst_n low at a clock edge) empties the pipeline and loads width 1920, height 1080,
// strength 0
module radial_vignette_pixel_top #(
    parameter int MAX_DIM = rvig_pkg::RVIG_MAX_DIM
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rvig_pkg::ADDR_W-1:0]   paddr,
    input  logic [rvig_pkg::DATA_W-1:0]   pwdata,
    output logic [rvig_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    rvig_in_if.sink                       i_pix,
    rvig_out_if.source                    o_pix
);

    localparam int COORD_W = rvig_pkg::COORD_W;
    localparam int DIM_W   = rvig_pkg::DIM_W;
    localparam int CH_W    = rvig_pkg::CH_W;
    localparam int STR_W   = rvig_pkg::STR_W;
    localparam int SQ_W    = rvig_pkg::SQ_W;
    localparam int D2_W    = rvig_pkg::D2_W;
    localparam int RATIO_W = rvig_pkg::RATIO_W;
    localparam int PROD_W  = rvig_pkg::PROD_W;
    localparam int DROP_W  = rvig_pkg::DROP_W;
    localparam int MASK_W  = rvig_pkg::MASK_W;
    localparam int ADDR_W  = rvig_pkg::ADDR_W;
    localparam int DATA_W  = rvig_pkg::DATA_W;
    localparam int PM_W    = RATIO_W + STR_W;
    localparam int RM_W    = PROD_W + rvig_pkg::RECIP_W;
    localparam int CM_W    = CH_W + MASK_W;

    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'(MAX_DIM - 1);
    localparam logic [DIM_W-1:0]   DIM_MASK   = DIM_W'(2 * MAX_DIM - 1);

    // ---------------- configuration registers ----------------
    logic [DIM_W-1:0]      r_frame_width;
    logic [DIM_W-1:0]      r_frame_height;
    logic [STR_W-1:0]      r_strength;
    logic [D2_W-1:0]       r_m2;
    logic                  cfg_wr;
    rvig_pkg::t_reg_idx    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = rvig_pkg::t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= rvig_pkg::FRAME_WIDTH_RST;
            r_frame_height <= rvig_pkg::FRAME_HEIGHT_RST;
            r_strength     <= rvig_pkg::STRENGTH_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                rvig_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DIM_W-1:0] & DIM_MASK;
                rvig_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[DIM_W-1:0] & DIM_MASK;
                rvig_pkg::REG_STRENGTH:     r_strength     <= pwdata[STR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            rvig_pkg::REG_FRAME_WIDTH:  prdata = DATA_W'(r_frame_width);
            rvig_pkg::REG_FRAME_HEIGHT: prdata = DATA_W'(r_frame_height);
            rvig_pkg::REG_STRENGTH:     prdata = DATA_W'(r_strength);
            default:                    prdata = '0;
        endcase
    end

    // squared half-diagonal in doubled coordinates (width^2 + height^2), only changes with the frame registers
    always_ff @(posedge i_clk) begin
        r_m2 <= D2_W'(SQ_W'(r_frame_width) * SQ_W'(r_frame_width))
              + D2_W'(SQ_W'(r_frame_height) * SQ_W'(r_frame_height));
    end

    // ---------------- pipeline control ----------------
    logic r_out_vld;
    logic en;

    assign en          = !r_out_vld || o_pix.ready;
    assign i_pix.ready = en;

    // ---------------- front stages ----------------
    logic                  r_s0_vld, r_s1_vld, r_s2_vld, r_s3_vld;
    logic [COORD_W-1:0]    r_s0_col, r_s0_row;
    rvig_pkg::t_pix        r_s0_pix, r_s1_pix, r_s2_pix, r_s3_pix;
    logic [DIM_W-1:0]      r_dx, r_dy;
    logic [SQ_W-1:0]       r_dx2, r_dy2;
    logic [D2_W-1:0]       r_d2;
    logic [DIM_W-1:0]      c2, r2;
    logic [DIM_W-1:0]      n_dx, n_dy;

    assign c2   = {r_s0_col, 1'b0};
    assign r2   = {r_s0_row, 1'b0};
    assign n_dx = (c2 >= r_frame_width)  ? c2 - r_frame_width  : r_frame_width - c2;
    assign n_dy = (r2 >= r_frame_height) ? r2 - r_frame_height : r_frame_height - r2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_col       <= i_pix.col & COORD_MASK;
            r_s0_row       <= i_pix.row & COORD_MASK;
            r_s0_pix.blue  <= i_pix.blue_in;
            r_s0_pix.green <= i_pix.green_in;
            r_s0_pix.red   <= i_pix.red_in;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_s1_pix <= r_s0_pix;
            r_dx2    <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_dy2    <= SQ_W'(r_dy) * SQ_W'(r_dy);
            r_s2_pix <= r_s1_pix;
            r_d2     <= D2_W'(r_dx2) + D2_W'(r_dy2);
            r_s3_pix <= r_s2_pix;
        end
    end

    // ---------------- ratio unit ----------------
    logic                  rat_vld;
    logic [RATIO_W-1:0]    rat_val;
    rvig_pkg::t_pix        rat_pix;

    rvig_ratio u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s3_vld),
        .i_d2    (r_d2),
        .i_m2    (r_m2),
        .i_pix   (r_s3_pix),
        .o_vld   (rat_vld),
        .o_ratio (rat_val),
        .o_pix   (rat_pix)
    );

    // ---------------- mask and scaling stages ----------------
    logic                  r_p1_vld, r_p2_vld, r_p3_vld;
    rvig_pkg::t_pix        r_p1_pix, r_p2_pix, r_p3_pix;
    logic [PROD_W-1:0]     r_prod;
    logic [DROP_W-1:0]     r_drop;
    logic [MASK_W-1:0]     r_mask;
    logic [CH_W-1:0]       r_blue, r_green, r_red;
    logic [PM_W-1:0]       prod_full;
    logic [RM_W-1:0]       recip_full;
    logic [MASK_W-1:0]     n_mask;
    logic [CM_W-1:0]       blue_full, green_full, red_full;

    assign prod_full  = PM_W'(rat_val) * PM_W'(r_strength);
    assign recip_full = RM_W'(r_prod) * RM_W'(rvig_pkg::RECIP_100);
    assign n_mask     = (r_drop >= DROP_W'(rvig_pkg::RATIO_ONE)) ? '0
                      : MASK_W'(DROP_W'(rvig_pkg::RATIO_ONE) - r_drop);
    assign blue_full  = CM_W'(r_p3_pix.blue)  * CM_W'(r_mask);
    assign green_full = CM_W'(r_p3_pix.green) * CM_W'(r_mask);
    assign red_full   = CM_W'(r_p3_pix.red)   * CM_W'(r_mask);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod   <= prod_full[PROD_W-1:0];
            r_p1_pix <= rat_pix;
            r_drop   <= recip_full[rvig_pkg::RECIP_SHIFT +: DROP_W];
            r_p2_pix <= r_p1_pix;
            r_mask   <= n_mask;
            r_p3_pix <= r_p2_pix;
            r_blue   <= blue_full[16 +: CH_W];
            r_green  <= green_full[16 +: CH_W];
            r_red    <= red_full[16 +: CH_W];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld  <= i_pix.valid;
            r_s1_vld  <= r_s0_vld;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_p1_vld  <= rat_vld;
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_out_vld <= r_p3_vld;
        end
    end

    assign o_pix.valid     = r_out_vld;
    assign o_pix.blue_out  = r_blue;
    assign o_pix.green_out = r_green;
    assign o_pix.red_out   = r_red;

endmodule
